@@ rtl/text_console_char_writer_assert.svh @@
// assertion macros for the text console character writer
// used by the top level only, clocked on the block clock with the active-low reset
`ifndef TEXT_CONSOLE_CHAR_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_WRITER_ASSERT_SVH

// condition holds at every edge out of reset
`define TCCW_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define TCCW_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tccw_pkg.sv @@
// shared constants and types for the text console character writer
// no dependencies
`timescale 1ns / 1ps

package tccw_pkg;

    localparam int DEFAULT_COLS = 80;
    localparam int DEFAULT_ROWS = 25;

    // field widths
    localparam int CMD_W       = 2;
    localparam int CHAR_W      = 8;
    localparam int ROW_W       = 5;
    localparam int COL_W       = 7;
    localparam int TAB_W       = 4;
    localparam int TOP_W       = 5;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 24;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SET  = 2'd2;

    // control characters
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_TAB_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCROLL_TOP = 2'd1;

    localparam logic [TAB_W-1:0] MIN_TAB = 4'd5;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCROLL,
        ST_FINISH
    } state_t;

endpackage

@@ rtl/tccw_cell_ram.sv @@
// character cell store: one write port, one read port, registered read data
// no dependencies
`timescale 1ns / 1ps

module tccw_cell_ram #(
    parameter int DEPTH  = 2000,
    parameter int DATA_W = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/text_console_char_writer.sv @@
// top level of the text console character writer: cursor logic, scroll and clear sweeps
// depends on tccw_pkg, tccw_cell_ram and text_console_char_writer_assert.svh
`timescale 1ns / 1ps

// Character-cell terminal over a ROWS x COLS store held in one block RAM. After reset
// the block sweeps all ROWS*COLS cells (2000 at 80x25) to spaces, one cell a cycle;
// s_tready stays low during that pass, configuration writes are taken. When a command
// is accepted, a put writes its cell or a read addresses the RAM; the finish state then
// loads the output register once it is free. A put that scrolls first sweeps the cells
// from scroll_top_row to the end of the screen, (ROWS - scroll_top_row) * COLS of them,
// since the row shift is a copy through the single RAM read port, one cell a cycle. A
// new command is taken while the previous result still waits on m_tready.
module text_console_char_writer #(
    parameter int COLS = tccw_pkg::DEFAULT_COLS,
    parameter int ROWS = tccw_pkg::DEFAULT_ROWS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // config
    input  logic                               cfg_we,
    input  logic [tccw_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tccw_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // command stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // cmd[1:0], char_code[9:2], row[14:10], col[21:15], zero[23:22]
    input  logic [tccw_pkg::IN_DATA_W-1:0]     s_tdata,
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // cursor_row[4:0], cursor_col[11:5], cell_char[19:12], scrolled[20], zero[23:21]
    output logic [tccw_pkg::OUT_DATA_W-1:0]    m_tdata
);

    `include "text_console_char_writer_assert.svh"

    localparam int NCELLS = ROWS * COLS;
    localparam int AW     = $clog2(NCELLS);
    localparam int RW     = $clog2(ROWS);
    localparam int CW     = $clog2(COLS);
    localparam int NW     = CW + 5;
    localparam int RSW    = RW + 2;

    localparam logic [AW-1:0] LAST_CELL  = AW'(NCELLS - 1);
    localparam logic [AW-1:0] LAST_ROW_0 = AW'(NCELLS - COLS);

    // input fields
    logic [tccw_pkg::CMD_W-1:0]  in_cmd;
    logic [tccw_pkg::CHAR_W-1:0] in_char;
    logic [tccw_pkg::ROW_W-1:0]  in_row;
    logic [tccw_pkg::COL_W-1:0]  in_col;

    assign in_cmd  = s_tdata[1:0];
    assign in_char = s_tdata[9:2];
    assign in_row  = s_tdata[14:10];
    assign in_col  = s_tdata[21:15];

    tccw_pkg::state_t state_reg, state_next;

    logic [AW-1:0]   p_reg, p_next;
    logic            wpend_reg;
    logic            wblank_reg;
    logic [AW-1:0]   waddr_q_reg;
    logic [RW-1:0]   row_reg, row_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [tccw_pkg::TAB_W-1:0] tab_reg;
    logic [RW-1:0]   top_reg;
    logic            res_read_reg, res_read_next;
    logic            res_scroll_reg, res_scroll_next;
    logic            m_valid_reg, m_valid_next;
    logic [tccw_pkg::OUT_DATA_W-1:0] m_data_reg;

    logic accept;
    logic out_free;
    logic finish_load;

    // ram ports
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [tccw_pkg::CHAR_W-1:0] ram_wdata;
    logic                        ram_re;
    logic [AW-1:0]               ram_raddr;
    logic [tccw_pkg::CHAR_W-1:0] ram_rdata;

    // saturated row and column of the command
    logic [RW+4:0] row_ext;
    logic [CW+6:0] col_ext;
    logic [RW-1:0] row_sat;
    logic [CW-1:0] col_sat;

    // put cursor step
    logic [NW-1:0]  nc_sum;
    logic [1:0]     radd;
    logic [CW-1:0]  nc;
    logic [RSW-1:0] nr;
    logic [RSW-1:0] nr_back;
    logic [RW-1:0]  put_row;
    logic [CW-1:0]  put_col;
    logic           put_scroll;
    logic           put_store;

    logic [AW-1:0]  cur_addr;
    logic [AW:0]    p_plus;

    tccw_cell_ram #(
        .DEPTH  (NCELLS),
        .DATA_W (tccw_pkg::CHAR_W),
        .ADDR_W (AW)
    ) u_cells (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready    = (state_reg == tccw_pkg::ST_IDLE);
    assign accept      = s_tvalid && s_tready;
    assign out_free    = !m_valid_reg || m_tready;
    assign finish_load = (state_reg == tccw_pkg::ST_FINISH) && out_free;
    assign m_tvalid    = m_valid_reg;
    assign m_tdata     = m_data_reg;

    assign cur_addr = AW'(row_reg * COLS) + AW'(col_reg);
    assign p_plus   = (AW + 1)'(p_reg) + (AW + 1)'(COLS);

    always_comb begin
        row_ext = (RW + 5)'(in_row);
        col_ext = (CW + 7)'(in_col);
        row_sat = (row_ext > (RW + 5)'(ROWS - 1)) ? RW'(ROWS - 1) : RW'(row_ext);
        col_sat = (col_ext > (CW + 7)'(COLS - 1)) ? CW'(COLS - 1) : CW'(col_ext);
    end

    // cursor after a put
    always_comb begin
        nc_sum     = '0;
        radd       = 2'd0;
        put_store  = 1'b0;
        case (in_char)
            tccw_pkg::CH_NEWLINE: begin
                radd = 2'd1;
            end
            tccw_pkg::CH_TAB: begin
                nc_sum = NW'(col_reg) + NW'(tab_reg);
            end
            default: begin
                nc_sum    = NW'(col_reg) + NW'(1);
                put_store = (in_char != tccw_pkg::CH_BACKSPACE);
            end
        endcase

        // a tab on a narrow screen can wrap over two rows
        if (nc_sum >= NW'(2 * COLS)) begin
            nc   = CW'(nc_sum - NW'(2 * COLS));
            radd = radd + 2'd2;
        end else if (nc_sum >= NW'(COLS)) begin
            nc   = CW'(nc_sum - NW'(COLS));
            radd = radd + 2'd1;
        end else begin
            nc = CW'(nc_sum);
        end

        nr         = RSW'(row_reg) + RSW'(radd);
        nr_back    = nr - RSW'(1);
        put_scroll = 1'b0;
        put_row    = RW'(nr);
        put_col    = nc;

        if (in_char == tccw_pkg::CH_BACKSPACE) begin
            if (col_reg != '0) begin
                put_row = row_reg;
                put_col = col_reg - CW'(1);
            end else if (row_reg != '0) begin
                put_row = row_reg - RW'(1);
                put_col = CW'(COLS - 1);
            end else begin
                put_row = row_reg;
                put_col = col_reg;
            end
        end else if (nr >= RSW'(ROWS)) begin
            put_scroll = 1'b1;
            if (nr_back >= RSW'(ROWS)) begin
                put_row = RW'(ROWS - 1);
                put_col = CW'(COLS - 1);
            end else begin
                put_row = RW'(nr_back);
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tccw_pkg::ST_CLEAR: begin
                if (p_reg == LAST_CELL) begin
                    state_next = tccw_pkg::ST_IDLE;
                end
            end
            tccw_pkg::ST_IDLE: begin
                if (accept) begin
                    if (in_cmd == tccw_pkg::CMD_PUT && put_scroll) begin
                        state_next = tccw_pkg::ST_SCROLL;
                    end else begin
                        state_next = tccw_pkg::ST_FINISH;
                    end
                end
            end
            tccw_pkg::ST_SCROLL: begin
                if (p_reg == LAST_CELL) begin
                    state_next = tccw_pkg::ST_FINISH;
                end
            end
            tccw_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = tccw_pkg::ST_IDLE;
                end
            end
            default: state_next = tccw_pkg::ST_CLEAR;
        endcase
    end

    // datapath and memory control
    always_comb begin
        p_next          = p_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        res_read_next   = res_read_reg;
        res_scroll_next = res_scroll_reg;
        ram_we          = 1'b0;
        ram_waddr       = waddr_q_reg;
        ram_wdata       = wblank_reg ? tccw_pkg::SPACE_CODE : ram_rdata;
        ram_re          = 1'b0;
        ram_raddr       = AW'(p_plus);

        // delayed write of the scroll copy
        if (wpend_reg) begin
            ram_we = 1'b1;
        end

        unique case (state_reg)
            tccw_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = p_reg;
                ram_wdata = tccw_pkg::SPACE_CODE;
                p_next    = p_reg + AW'(1);
            end
            tccw_pkg::ST_IDLE: begin
                if (accept) begin
                    res_read_next   = (in_cmd == tccw_pkg::CMD_READ);
                    res_scroll_next = 1'b0;
                    case (in_cmd)
                        tccw_pkg::CMD_PUT: begin
                            row_next        = put_row;
                            col_next        = put_col;
                            res_scroll_next = put_scroll;
                            p_next          = AW'(top_reg * COLS);
                            if (put_store) begin
                                ram_we    = 1'b1;
                                ram_waddr = cur_addr;
                                ram_wdata = in_char;
                            end
                        end
                        tccw_pkg::CMD_READ: begin
                            ram_re    = 1'b1;
                            ram_raddr = AW'(row_sat * COLS) + AW'(col_sat);
                        end
                        tccw_pkg::CMD_SET: begin
                            row_next = row_sat;
                            col_next = col_sat;
                        end
                        default: ;
                    endcase
                end
            end
            tccw_pkg::ST_SCROLL: begin
                // fetch the cell one row below; the last row only blanks
                ram_re = (p_reg < LAST_ROW_0);
                p_next = p_reg + AW'(1);
            end
            tccw_pkg::ST_FINISH: ;
            default: ;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (finish_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= tccw_pkg::ST_CLEAR;
            p_reg          <= '0;
            wpend_reg      <= 1'b0;
            row_reg        <= '0;
            col_reg        <= '0;
            tab_reg        <= tccw_pkg::MIN_TAB;
            top_reg        <= '0;
            res_read_reg   <= 1'b0;
            res_scroll_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            p_reg          <= p_next;
            wpend_reg      <= (state_reg == tccw_pkg::ST_SCROLL);
            row_reg        <= row_next;
            col_reg        <= col_next;
            res_read_reg   <= res_read_next;
            res_scroll_reg <= res_scroll_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    tccw_pkg::REG_TAB_WIDTH: begin
                        if (cfg_wdata[tccw_pkg::TAB_W-1:0] >= tccw_pkg::MIN_TAB) begin
                            tab_reg <= cfg_wdata[tccw_pkg::TAB_W-1:0];
                        end
                    end
                    tccw_pkg::REG_SCROLL_TOP: begin
                        if ((RW + 5)'(cfg_wdata) > (RW + 5)'(ROWS - 1)) begin
                            top_reg <= RW'(ROWS - 1);
                        end else begin
                            top_reg <= RW'(cfg_wdata);
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        waddr_q_reg <= p_reg;
        wblank_reg  <= (p_reg >= LAST_ROW_0);
        if (finish_load) begin
            m_data_reg <= {3'b000,
                           res_scroll_reg,
                           res_read_reg ? ram_rdata : tccw_pkg::SPACE_CODE & 8'h00,
                           tccw_pkg::COL_W'(col_reg),
                           tccw_pkg::ROW_W'(row_reg)};
        end
    end

    `TCCW_ASSERT_ALWAYS(a_cursor_in_range, aclk, aresetn,
        (row_reg <= RW'(ROWS - 1)) && (col_reg <= CW'(COLS - 1)),
        "cursor left the screen")

    `TCCW_ASSERT_NEXT(a_one_item_at_a_time, aclk, aresetn,
        accept, state_reg != tccw_pkg::ST_IDLE,
        "command accepted without leaving idle")

    `TCCW_ASSERT_NEXT(a_result_loaded, aclk, aresetn,
        finish_load, m_valid_reg && state_reg == tccw_pkg::ST_IDLE,
        "finished command did not present a result")

endmodule

@@ tb/tb.sv @@
// self-checking testbench for the text console character writer
// drives command words against a cycle-free model of the screen; needs tccw_pkg and the block
`timescale 1ns / 1ps

module tb;

    localparam int COLS = tccw_pkg::DEFAULT_COLS;
    localparam int ROWS = tccw_pkg::DEFAULT_ROWS;
    localparam int NCELLS = ROWS * COLS;
    // a scroll copies up to the whole screen through one port, plus room for the result to drain
    localparam int SCROLL_DRAIN = NCELLS + 64;
    localparam int CYCLE_LIMIT = 1400 * (NCELLS + 40) * 3;
    localparam int HOLD_AT = 260;
    localparam int LONG_HOLD = 400;
    localparam int RANDOM_PER_PHASE = 155;

    localparam logic [tccw_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [tccw_pkg::CFG_INDEX_W-1:0] REG_UNUSED_2 = 2'd2;
    localparam logic [tccw_pkg::CFG_INDEX_W-1:0] REG_UNUSED_3 = 2'd3;

    typedef struct packed {
        logic [tccw_pkg::CMD_W-1:0]  cmd;
        logic [tccw_pkg::CHAR_W-1:0] code;
        logic [tccw_pkg::ROW_W-1:0]  row;
        logic [tccw_pkg::COL_W-1:0]  col;
    } console_cmd_t;

    typedef struct packed {
        logic [tccw_pkg::ROW_W-1:0]  cur_row;
        logic [tccw_pkg::COL_W-1:0]  cur_col;
        logic [tccw_pkg::CHAR_W-1:0] cell_char;
        logic                        scrolled;
    } console_status_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [tccw_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [tccw_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [tccw_pkg::IN_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [tccw_pkg::OUT_DATA_W-1:0] m_tdata;

    // screen model
    logic [tccw_pkg::CHAR_W-1:0] screen_shadow [NCELLS];
    int cursor_shadow = 0;
    int tab_shadow = 5;
    int top_shadow = 0;

    console_cmd_t pending_cmds [$];
    console_status_t expected_status [$];
    console_cmd_t offered_cmd;
    console_status_t got, want;

    int cmds_queued = 0;
    int cmds_accepted = 0;
    int status_checked = 0;
    int results_seen = 0;
    int mismatches = 0;
    int scrolls_seen = 0;
    int reads_sent = 0;
    int reg_writes = 0;
    int settings_run = 0;
    int cycle_count = 0;
    int launches = 0;
    int src_gap = 0;
    int sink_stall = 0;
    int hold_left = 0;
    bit src_idle_on = 1'b1;
    bit sink_idle_on = 1'b1;

    text_console_char_writer #(.COLS(COLS), .ROWS(ROWS)) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic console_status_t console_apply(console_cmd_t c);
        console_status_t res;
        int r, cc, pos, k;
        res = '0;
        r = (c.row > ROWS - 1) ? ROWS - 1 : int'(c.row);
        cc = (c.col > COLS - 1) ? COLS - 1 : int'(c.col);
        if (cursor_shadow >= NCELLS) cursor_shadow = NCELLS - 1;
        case (c.cmd)
            tccw_pkg::CMD_PUT: begin
                pos = cursor_shadow;
                if (c.code == tccw_pkg::CH_NEWLINE) begin
                    pos = (pos / COLS + 1) * COLS;
                end else if (c.code == tccw_pkg::CH_TAB) begin
                    pos += tab_shadow;
                end else if (c.code == tccw_pkg::CH_BACKSPACE) begin
                    if (pos > 0) pos--;
                end else begin
                    screen_shadow[pos] = c.code;
                    pos++;
                end
                if (pos >= NCELLS) begin
                    // rows from the scroll top move up one, last row blanks
                    for (k = top_shadow * COLS; k < (ROWS - 1) * COLS; k++)
                        screen_shadow[k] = screen_shadow[k + COLS];
                    for (k = (ROWS - 1) * COLS; k < NCELLS; k++)
                        screen_shadow[k] = tccw_pkg::SPACE_CODE;
                    res.scrolled = 1'b1;
                    pos -= COLS;
                    if (pos >= NCELLS) pos = NCELLS - 1;
                end
                cursor_shadow = pos;
            end
            tccw_pkg::CMD_READ: res.cell_char = screen_shadow[r * COLS + cc];
            tccw_pkg::CMD_SET: cursor_shadow = r * COLS + cc;
            default: ;
        endcase
        res.cur_row = tccw_pkg::ROW_W'(cursor_shadow / COLS);
        res.cur_col = tccw_pkg::COL_W'(cursor_shadow % COLS);
        return res;
    endfunction

    function automatic console_cmd_t random_cmd();
        console_cmd_t c;
        int pick;
        c.code = tccw_pkg::CHAR_W'($urandom_range(0, 255));
        c.row = tccw_pkg::ROW_W'($urandom_range(0, 31));
        c.col = tccw_pkg::COL_W'($urandom_range(0, 127));
        pick = $urandom_range(0, 99);
        if (pick < 62) begin
            c.cmd = tccw_pkg::CMD_PUT;
            pick = $urandom_range(0, 99);
            if (pick < 9) c.code = tccw_pkg::CH_NEWLINE;
            else if (pick < 17) c.code = tccw_pkg::CH_TAB;
            else if (pick < 25) c.code = tccw_pkg::CH_BACKSPACE;
        end else if (pick < 80) begin
            c.cmd = tccw_pkg::CMD_READ;
            // bottom rows are where scrolled text piles up
            if ($urandom_range(0, 1) != 0) c.row = tccw_pkg::ROW_W'($urandom_range(18, 31));
        end else if (pick < 97) begin
            c.cmd = tccw_pkg::CMD_SET;
        end else begin
            c.cmd = CMD_UNUSED;
        end
        return c;
    endfunction

    function automatic void queue_cmd(logic [tccw_pkg::CMD_W-1:0] cmd,
                                      logic [tccw_pkg::CHAR_W-1:0] code,
                                      logic [tccw_pkg::ROW_W-1:0] row,
                                      logic [tccw_pkg::COL_W-1:0] col);
        console_cmd_t c;
        c.cmd = cmd;
        c.code = code;
        c.row = row;
        c.col = col;
        pending_cmds.push_back(c);
        cmds_queued++;
    endfunction

    task automatic queue_random(int n);
        repeat (n) begin
            pending_cmds.push_back(random_cmd());
            cmds_queued++;
        end
    endtask

    // wait for every word to come back, then for any trailing scroll
    task automatic settle();
        while (pending_cmds.size() != 0 || cmds_accepted != cmds_queued ||
               status_checked != cmds_accepted)
            @(posedge aclk);
        repeat (SCROLL_DRAIN) @(posedge aclk);
    endtask

    task automatic write_reg(logic [tccw_pkg::CFG_INDEX_W-1:0] idx,
                             logic [tccw_pkg::CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        reg_writes++;
        if (idx == tccw_pkg::REG_TAB_WIDTH) begin
            if (val[tccw_pkg::TAB_W-1:0] >= tccw_pkg::MIN_TAB)
                tab_shadow = int'(val[tccw_pkg::TAB_W-1:0]);
        end else if (idx == tccw_pkg::REG_SCROLL_TOP) begin
            top_shadow = (val > ROWS - 1) ? ROWS - 1 : int'(val);
        end
    endtask

    // command source
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_status.push_back(console_apply(offered_cmd));
                cmds_accepted++;
                if (offered_cmd.cmd == tccw_pkg::CMD_READ) reads_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap != 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    offered_cmd = pending_cmds.pop_front();
                    s_tdata <= {2'b00, offered_cmd.col, offered_cmd.row,
                                offered_cmd.code, offered_cmd.cmd};
                    s_tvalid <= 1'b1;
                    launches++;
                    if (launches % 64 == 0) src_idle_on = ($urandom_range(0, 3) != 0);
                    src_gap = src_idle_on ? int'($urandom_range(0, 11)) : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result sink and checker
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (hold_left != 0) hold_left--;
            else if (sink_stall != 0) sink_stall--;
            if (m_tvalid && m_tready) begin
                results_seen++;
                got.cur_row = m_tdata[4:0];
                got.cur_col = m_tdata[11:5];
                got.cell_char = m_tdata[19:12];
                got.scrolled = m_tdata[20];
                if (got.scrolled) scrolls_seen++;
                if (expected_status.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("error: result word %h arrived with nothing expected", m_tdata);
                end else begin
                    want = expected_status.pop_front();
                    status_checked++;
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("error: word %0d expected row %0d col %0d char %h scrolled %b",
                                     status_checked, want.cur_row, want.cur_col,
                                     want.cell_char, want.scrolled);
                            $display("       got row %0d col %0d char %h scrolled %b",
                                     got.cur_row, got.cur_col, got.cell_char, got.scrolled);
                        end
                    end
                end
                if (results_seen % 64 == 0) sink_idle_on = ($urandom_range(0, 3) != 0);
                sink_stall = sink_idle_on ? int'($urandom_range(0, 11)) : 0;
                // one long back-pressure stretch so the block fills and stalls its input
                if (results_seen == HOLD_AT) hold_left = LONG_HOLD;
            end
            m_tready <= (hold_left == 0 && sink_stall == 0);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                     expected_status.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < NCELLS; i++) screen_shadow[i] = tccw_pkg::SPACE_CODE;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // reset values of both registers
        settings_run++;
        queue_cmd(tccw_pkg::CMD_READ, 8'h00, 5'd0, 7'd0);
        queue_cmd(tccw_pkg::CMD_READ, 8'hFF, 5'd31, 7'd127);
        queue_cmd(tccw_pkg::CMD_PUT, 8'h41, 5'd0, 7'd0);
        queue_cmd(tccw_pkg::CMD_PUT, 8'hFF, 5'd31, 7'd127);
        queue_cmd(tccw_pkg::CMD_PUT, 8'h00, 5'd0, 7'd0);
        queue_cmd(tccw_pkg::CMD_PUT, tccw_pkg::CH_TAB, 5'd0, 7'd0);
        queue_cmd(tccw_pkg::CMD_PUT, tccw_pkg::CH_BACKSPACE, 5'd0, 7'd0);
        queue_cmd(tccw_pkg::CMD_PUT, tccw_pkg::CH_NEWLINE, 5'd0, 7'd0);
        queue_cmd(tccw_pkg::CMD_PUT, tccw_pkg::SPACE_CODE, 5'd0, 7'd0);
        queue_cmd(tccw_pkg::CMD_READ, 8'h00, 5'd0, 7'd1);
        queue_cmd(tccw_pkg::CMD_SET, 8'h00, 5'd0, 7'd0);
        queue_cmd(tccw_pkg::CMD_PUT, tccw_pkg::CH_BACKSPACE, 5'd0, 7'd0);
        queue_cmd(tccw_pkg::CMD_SET, 8'h00, 5'd3, 7'd78);
        queue_cmd(tccw_pkg::CMD_PUT, tccw_pkg::CH_TAB, 5'd0, 7'd0);
        queue_cmd(tccw_pkg::CMD_SET, 8'h00, 5'd0, 7'd127);
        queue_cmd(tccw_pkg::CMD_PUT, 8'h78, 5'd0, 7'd0);
        // last cell, then a character past it scrolls
        queue_cmd(tccw_pkg::CMD_SET, 8'h00, 5'd31, 7'd127);
        queue_cmd(tccw_pkg::CMD_PUT, 8'h5A, 5'd0, 7'd0);
        queue_cmd(tccw_pkg::CMD_READ, 8'h00, 5'd23, 7'd79);
        queue_cmd(tccw_pkg::CMD_READ, 8'h00, 5'd0, 7'd0);
        queue_cmd(tccw_pkg::CMD_SET, 8'h00, 5'd24, 7'd77);
        queue_cmd(tccw_pkg::CMD_PUT, tccw_pkg::CH_TAB, 5'd0, 7'd0);
        queue_cmd(tccw_pkg::CMD_PUT, tccw_pkg::CH_NEWLINE, 5'd0, 7'd0);
        queue_cmd(tccw_pkg::CMD_PUT, 8'h7E, 5'd0, 7'd0);
        queue_cmd(CMD_UNUSED, 8'hAA, 5'd21, 7'd85);
        settle();

        // widest tab, only the last row scrolls
        write_reg(tccw_pkg::REG_TAB_WIDTH, 5'd15);
        write_reg(tccw_pkg::REG_SCROLL_TOP, 5'd24);
        settings_run++;
        queue_cmd(tccw_pkg::CMD_SET, 8'h00, 5'd24, 7'd75);
        queue_cmd(tccw_pkg::CMD_PUT, tccw_pkg::CH_TAB, 5'd0, 7'd0);
        queue_cmd(tccw_pkg::CMD_READ, 8'h00, 5'd23, 7'd79);
        queue_random(RANDOM_PER_PHASE);
        settle();

        // tab below minimum is dropped, top past the last row saturates, bad indexes ignored
        write_reg(tccw_pkg::REG_TAB_WIDTH, 5'd4);
        write_reg(tccw_pkg::REG_SCROLL_TOP, 5'd31);
        write_reg(REG_UNUSED_2, 5'h1F);
        write_reg(REG_UNUSED_3, 5'h00);
        settings_run++;
        queue_random(RANDOM_PER_PHASE);
        settle();

        // upper data bit is not part of the tab width
        write_reg(tccw_pkg::REG_TAB_WIDTH, 5'b10101);
        write_reg(tccw_pkg::REG_SCROLL_TOP, 5'd0);
        settings_run++;
        queue_random(RANDOM_PER_PHASE);
        settle();

        write_reg(tccw_pkg::REG_TAB_WIDTH, 5'd0);
        write_reg(tccw_pkg::REG_SCROLL_TOP, 5'd12);
        settings_run++;
        queue_random(RANDOM_PER_PHASE);
        settle();

        repeat (4) begin
            write_reg(tccw_pkg::REG_TAB_WIDTH, tccw_pkg::CFG_DATA_W'($urandom_range(0, 31)));
            write_reg(tccw_pkg::REG_SCROLL_TOP, tccw_pkg::CFG_DATA_W'($urandom_range(0, 31)));
            if ($urandom_range(0, 1) != 0)
                write_reg(($urandom_range(0, 1) != 0) ? REG_UNUSED_2 : REG_UNUSED_3,
                          tccw_pkg::CFG_DATA_W'($urandom_range(0, 31)));
            settings_run++;
            queue_random(RANDOM_PER_PHASE);
            settle();
        end

        $display("ran %0d commands (%0d reads, %0d scrolls) under %0d register settings",
                 cmds_accepted, reads_sent, scrolls_seen, settings_run);
        $display("%0d register writes, %0d mismatches, %0d results left over", reg_writes,
                 mismatches, expected_status.size());
        if (mismatches == 0 && expected_status.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ text_console_char_writer.f @@
+incdir+rtl
rtl/tccw_pkg.sv
rtl/tccw_cell_ram.sv
rtl/text_console_char_writer.sv
tb/tb.sv
